@@ hw/rtl/psp_pkg.sv @@
// ============================================================================
// psp_pkg
// Shared widths, codes and helpers for the polar stereographic projector.
// ============================================================================
package psp_pkg;

    localparam int COORD_WIDTH  = 16;                       // block-normalised width
    localparam int IN_W         = 16;                       // Q2.14 input component
    localparam int OUT_W        = 24;                       // Q8.16 plane coordinate
    localparam int PROD_W       = 2 * IN_W;
    localparam int SUM_W        = PROD_W + 2;
    localparam int MAG_W        = PROD_W;
    localparam int MSB_W        = $clog2(MAG_W);
    localparam int AM_W         = COORD_WIDTH - 1;
    localparam int SQ1_W        = 2 * AM_W;
    localparam int SQ_W         = SQ1_W + 2;
    localparam int ROOT_W       = SQ_W / 2;
    localparam int DEN_W        = ROOT_W + 1;
    localparam int NUM_W        = AM_W + DEN_W + 1;         // (m << 17) + den
    localparam int DIV_BITS     = OUT_W + 1;
    localparam int REM_W        = DEN_W + 1;
    localparam int ISQRT_STAGES = ROOT_W;
    localparam int DIV_STAGES   = DIV_BITS + 1;
    localparam int FRONT_STAGES = 7;
    localparam int PIPE_DEPTH   = FRONT_STAGES + ISQRT_STAGES + 1 + DIV_STAGES + 1;

    localparam int ROW_W        = 3 * IN_W;
    localparam int PDATA_W      = 64;
    localparam int PADDR_W      = 5;

    localparam logic [1:0] REG_ROW0 = 2'd0;
    localparam logic [1:0] REG_ROW1 = 2'd1;
    localparam logic [1:0] REG_ROW2 = 2'd2;
    localparam logic [1:0] REG_POLE = 2'd3;

    localparam logic [ROW_W-1:0] ROW0_RESET = ROW_W'(16384);
    localparam logic [ROW_W-1:0] ROW1_RESET = ROW_W'(16384) << IN_W;
    localparam logic [ROW_W-1:0] ROW2_RESET = ROW_W'(16384) << (2 * IN_W);

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_SAT  = 2'd1;
    localparam logic [1:0] STAT_ZERO = 2'd2;

    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef struct packed {
        logic [DIV_BITS-1:0] q;
        logic                neg;
        logic                ovf;
        logic                zn;
    } div_out_t;

    typedef struct packed {
        logic [OUT_W-1:0] val;
        logic             sat;
    } fmt_t;

    typedef struct packed {
        logic [2:0][AM_W-1:0] am;
        logic [2:0]           sgn;
        logic                 zero;
    } side_t;

    function automatic logic [MSB_W-1:0] msb_pos(input logic [MAG_W-1:0] v);
        logic [MSB_W-1:0] p;
        p = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (v[i])
                p = MSB_W'(i);
        end
        return p;
    endfunction

    // Format the rounded quotient as signed Q8.16 with saturation
    function automatic fmt_t fmt_quot(input div_out_t d);
        fmt_t r;
        logic [DIV_BITS-1:0] neg_q;
        neg_q = '0 - d.q;
        r.sat = 1'b0;
        r.val = '0;
        if (d.zn)
            r.val = '0;
        else if (d.ovf)
        begin
            r.sat = 1'b1;
            r.val = d.neg ? OUT_MIN : OUT_MAX;
        end
        else if (!d.neg)
        begin
            if (d.q > {1'b0, OUT_MAX})
            begin
                r.sat = 1'b1;
                r.val = OUT_MAX;
            end
            else
                r.val = d.q[OUT_W-1:0];
        end
        else
        begin
            // magnitude limit 2^23 on the negative side
            if (d.q > {2'b01, {(OUT_W-1){1'b0}}})
            begin
                r.sat = 1'b1;
                r.val = OUT_MIN;
            end
            else
                r.val = neg_q[OUT_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/psp_isqrt.sv @@
// ============================================================================
// psp_isqrt
// Pipelined floor integer square root, one result bit per stage.
// ============================================================================
module psp_isqrt
    import psp_pkg::*;
(
    input  logic              clk,
    input  logic              adv,
    input  logic [SQ_W-1:0]   sq,
    output logic [ROOT_W-1:0] root
);

    logic [SQ_W-1:0] v_reg   [ISQRT_STAGES];
    logic [SQ_W-1:0] res_reg [ISQRT_STAGES];
    logic [SQ_W-1:0] v_in    [ISQRT_STAGES];
    logic [SQ_W-1:0] res_in  [ISQRT_STAGES];
    logic [SQ_W-1:0] bitv    [ISQRT_STAGES];
    logic [SQ_W:0]   trial   [ISQRT_STAGES];

    always_comb
    begin
        for (int k = 0; k < ISQRT_STAGES; k++)
        begin
            v_in[k]   = (k == 0) ? sq : v_reg[(k == 0) ? 0 : k - 1];
            res_in[k] = (k == 0) ? '0 : res_reg[(k == 0) ? 0 : k - 1];
            bitv[k]   = SQ_W'(1) << (SQ_W - 2 - 2 * k);
            trial[k]  = {1'b0, res_in[k]} + {1'b0, bitv[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < ISQRT_STAGES; k++)
            begin
                if ({1'b0, v_in[k]} >= trial[k])
                begin
                    v_reg[k]   <= v_in[k] - trial[k][SQ_W-1:0];
                    res_reg[k] <= (res_in[k] >> 1) + bitv[k];
                end
                else
                begin
                    v_reg[k]   <= v_in[k];
                    res_reg[k] <= res_in[k] >> 1;
                end
            end
        end
    end

    assign root = res_reg[ISQRT_STAGES-1][ROOT_W-1:0];

endmodule

@@ hw/rtl/psp_div.sv @@
// ============================================================================
// psp_div
// Pipelined restoring divider: round((m << 16) / den), one bit per stage after the first.
// ============================================================================
module psp_div
    import psp_pkg::*;
(
    input  logic             clk,
    input  logic             adv,
    input  logic [AM_W-1:0]  num,
    input  logic             neg,
    input  logic [DEN_W-1:0] den,
    output div_out_t         res
);

    localparam int HI_W = NUM_W - DIV_BITS;

    logic [REM_W-1:0]    rem_reg [DIV_STAGES];
    logic [DIV_BITS-1:0] nr_reg  [DIV_STAGES];
    logic [REM_W-1:0]    d_reg   [DIV_STAGES];
    logic [DIV_BITS-1:0] q_reg   [DIV_STAGES];
    logic                neg_reg [DIV_STAGES];
    logic                ovf_reg [DIV_STAGES];
    logic                zn_reg  [DIV_STAGES];

    logic [NUM_W-1:0] n_full;
    logic [REM_W-1:0] d_full;
    logic [HI_W-1:0]  n_hi;
    logic [REM_W:0]   trial [DIV_STAGES];
    logic             ge    [DIV_STAGES];

    // numerator (m << 17) + den, divisor den << 1: rounds half away from zero
    assign n_full = {1'b0, num, {(DEN_W){1'b0}}} + NUM_W'(den);
    assign d_full = {den, 1'b0};
    assign n_hi   = n_full[NUM_W-1:DIV_BITS];

    always_comb
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            trial[s] = '0;
            ge[s]    = 1'b0;
            if (s > 0)
            begin
                trial[s] = {rem_reg[s-1], nr_reg[s-1][DIV_BITS-1]};
                ge[s]    = trial[s] >= {1'b0, d_reg[s-1]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_reg[0] <= REM_W'(n_hi);
            nr_reg[0]  <= n_full[DIV_BITS-1:0];
            d_reg[0]   <= d_full;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
            ovf_reg[0] <= REM_W'(n_hi) >= d_full;
            zn_reg[0]  <= (num == '0);
            for (int s = 1; s < DIV_STAGES; s++)
            begin
                rem_reg[s] <= ge[s] ? trial[s][REM_W-1:0] - d_reg[s-1]
                                    : trial[s][REM_W-1:0];
                nr_reg[s]  <= nr_reg[s-1] << 1;
                d_reg[s]   <= d_reg[s-1];
                q_reg[s]   <= {q_reg[s-1][DIV_BITS-2:0], ge[s]};
                neg_reg[s] <= neg_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
                zn_reg[s]  <= zn_reg[s-1];
            end
        end
    end

    assign res.q   = q_reg[DIV_STAGES-1];
    assign res.neg = neg_reg[DIV_STAGES-1];
    assign res.ovf = ovf_reg[DIV_STAGES-1];
    assign res.zn  = zn_reg[DIV_STAGES-1];

endmodule

@@ hw/rtl/polar_stereographic_projection_top.sv @@
// ============================================================================
// polar_stereographic_projection_top
// Rotate a Q2.14 direction, block-normalise, take |r| and project onto the
// tangent plane of the selected pole: (x, y) / (|r| +- z) in Q8.16.
// ============================================================================
//
//  channel   dir   width  content
//  s_axis    in    48     dir_x [15:0], dir_y [31:16], dir_z [47:32]
//  m_axis    out   48+2   tdata plane_u [23:0], plane_v [47:24]; tuser status
//  apb       in    64     rot_row0 @0x00, rot_row1 @0x08, rot_row2 @0x10,
//                         pole_select @0x18
//
//  One item per cycle unless the output stalls. Stages: 7 front stages
//  (multiply, sum, magnitude, leading one, shift, square, sum of squares),
//  16 root stages, 1 denominator stage, 26 divider stages, 1 output stage.
//  The whole pipe advances together; it holds only while the output item is
//  stalled, so s_tready drops exactly then. Nothing to clear after reset.
// ============================================================================
module polar_stereographic_projection_top
    import psp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // s_axis
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [47:0]        s_tdata,   // dir_x, dir_y, dir_z
    // m_axis
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [47:0]        m_tdata,   // plane_u, plane_v
    output logic [1:0]         m_tuser,   // status
    // apb
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    // ---------------- configuration ----------------
    logic [ROW_W-1:0] row_reg [3];
    logic             pole_reg;
    logic [1:0]       reg_idx;
    logic             wr_en;

    assign reg_idx = paddr[PADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW0_RESET;
            row_reg[1] <= ROW1_RESET;
            row_reg[2] <= ROW2_RESET;
            pole_reg   <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_ROW0: row_reg[0] <= pwdata[ROW_W-1:0];
                REG_ROW1: row_reg[1] <= pwdata[ROW_W-1:0];
                REG_ROW2: row_reg[2] <= pwdata[ROW_W-1:0];
                REG_POLE: pole_reg   <= pwdata[0];
                default:  pole_reg   <= pole_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_ROW0: prdata = PDATA_W'(row_reg[0]);
            REG_ROW1: prdata = PDATA_W'(row_reg[1]);
            REG_ROW2: prdata = PDATA_W'(row_reg[2]);
            REG_POLE: prdata = PDATA_W'(pole_reg);
            default:  prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // single advance for every stage; output register frees the input side
    logic                  adv;
    logic [PIPE_DEPTH-1:0] vld_reg;

    assign adv      = !vld_reg[PIPE_DEPTH-1] || m_tready;
    assign s_tready = adv;
    assign m_tvalid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_tvalid};
    end

    // ---------------- front stages ----------------
    logic signed [PROD_W-1:0] prod_reg [3][3];
    logic signed [SUM_W-1:0]  r_reg    [3];
    logic [MAG_W-1:0]         mag_reg  [3];
    logic [2:0]               sgn_reg;
    logic [MAG_W-1:0]         mag4_reg [3];
    logic [2:0]               sgn4_reg;
    logic [MSB_W-1:0]         msb_reg;
    logic                     zero4_reg;
    logic [AM_W-1:0]          am_reg   [3];
    logic [2:0]               sgn5_reg;
    logic                     zero5_reg;
    logic [SQ1_W-1:0]         sq_reg   [3];
    logic [AM_W-1:0]          am6_reg  [3];
    logic [2:0]               sgn6_reg;
    logic                     zero6_reg;
    logic [SQ_W-1:0]          sqs_reg;
    side_t                    side7_reg;

    logic signed [IN_W-1:0]   d_in [3];
    logic signed [SUM_W-1:0]  r_neg [3];
    logic [MAG_W-1:0]         m_max;
    logic [MAG_W+AM_W-2:0]    wide [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
            d_in[j] = $signed(s_tdata[IN_W*j +: IN_W]);
        for (int i = 0; i < 3; i++)
        begin
            r_neg[i] = -r_reg[i];
            wide[i]  = {mag4_reg[i], {(AM_W-1){1'b0}}} >> msb_reg;
        end
        m_max = (mag_reg[0] > mag_reg[1]) ? mag_reg[0] : mag_reg[1];
        if (mag_reg[2] > m_max)
            m_max = mag_reg[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Q4.28 products
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    prod_reg[i][j] <= $signed(row_reg[i][IN_W*j +: IN_W]) * d_in[j];
            for (int i = 0; i < 3; i++)
            begin
                r_reg[i]    <= SUM_W'(prod_reg[i][0]) + SUM_W'(prod_reg[i][1])
                             + SUM_W'(prod_reg[i][2]);
                mag_reg[i]  <= r_reg[i][SUM_W-1] ? r_neg[i][MAG_W-1:0]
                                                 : r_reg[i][MAG_W-1:0];
                sgn_reg[i]  <= r_reg[i][SUM_W-1];
                mag4_reg[i] <= mag_reg[i];
                // top set bit of the largest component lands on bit AM_W-1
                am_reg[i]   <= wide[i][AM_W-1:0];
                sq_reg[i]   <= am_reg[i] * am_reg[i];
                am6_reg[i]  <= am_reg[i];
            end
            sgn4_reg  <= sgn_reg;
            msb_reg   <= msb_pos(m_max);
            zero4_reg <= (m_max == '0);
            sgn5_reg  <= sgn4_reg;
            zero5_reg <= zero4_reg;
            sgn6_reg  <= sgn5_reg;
            zero6_reg <= zero5_reg;
            sqs_reg   <= SQ_W'(sq_reg[0]) + SQ_W'(sq_reg[1]) + SQ_W'(sq_reg[2]);
            for (int i = 0; i < 3; i++)
                side7_reg.am[i] <= am6_reg[i];
            side7_reg.sgn  <= sgn6_reg;
            side7_reg.zero <= zero6_reg;
        end
    end

    // ---------------- |r| ----------------
    logic [ROOT_W-1:0] root;
    side_t             side_reg [ISQRT_STAGES];

    psp_isqrt u_isqrt
    (
        .clk  (clk),
        .adv  (adv),
        .sq   (sqs_reg),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side7_reg;
            for (int k = 1; k < ISQRT_STAGES; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    // ---------------- denominator |r| +- z ----------------
    side_t                  sd;
    logic signed [DEN_W:0]  a_z;
    logic signed [DEN_W:0]  den_s;
    logic [DEN_W-1:0]       den_reg;
    logic [AM_W-1:0]        nu_reg;
    logic [AM_W-1:0]        nv_reg;
    logic                   su_reg;
    logic                   sv_reg;
    logic                   zero_d_reg;

    assign sd    = side_reg[ISQRT_STAGES-1];
    assign a_z   = sd.sgn[2] ? -$signed({3'b000, sd.am[2]}) : $signed({3'b000, sd.am[2]});
    // |r| >= |z|, so the result is never negative
    assign den_s = pole_reg ? $signed({2'b00, root}) - a_z : $signed({2'b00, root}) + a_z;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg    <= den_s[DEN_W-1:0];
            nu_reg     <= sd.am[0];
            nv_reg     <= sd.am[1];
            su_reg     <= sd.sgn[0];
            sv_reg     <= sd.sgn[1];
            zero_d_reg <= sd.zero;
        end
    end

    // ---------------- dividers ----------------
    div_out_t du;
    div_out_t dv;
    logic     zd_reg [DIV_STAGES];

    psp_div u_div_u
    (
        .clk (clk),
        .adv (adv),
        .num (nu_reg),
        .neg (su_reg),
        .den (den_reg),
        .res (du)
    );

    psp_div u_div_v
    (
        .clk (clk),
        .adv (adv),
        .num (nv_reg),
        .neg (sv_reg),
        .den (den_reg),
        .res (dv)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zd_reg[0] <= zero_d_reg;
            for (int s = 1; s < DIV_STAGES; s++)
                zd_reg[s] <= zd_reg[s-1];
        end
    end

    // ---------------- output register ----------------
    fmt_t       fu;
    fmt_t       fv;
    logic [47:0] tdata_reg;
    logic [1:0]  tuser_reg;

    assign fu = fmt_quot(du);
    assign fv = fmt_quot(dv);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (zd_reg[DIV_STAGES-1])
            begin
                tdata_reg <= '0;
                tuser_reg <= STAT_ZERO;
            end
            else
            begin
                tdata_reg <= {fv.val, fu.val};
                tuser_reg <= (fu.sat || fv.sat) ? STAT_SAT : STAT_OK;
            end
        end
    end

    assign m_tdata = tdata_reg;
    assign m_tuser = tuser_reg;

endmodule

@@ hw/rtl/psp_checker.sv @@
// ============================================================================
// psp_checker
// Port-level checks on the projector, bound to the top level.
// ============================================================================
module psp_checker
    import psp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [47:0]        s_tdata,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [47:0]        m_tdata,
    input logic [1:0]         m_tuser,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [PDATA_W-1:0] pwdata,
    input logic [PDATA_W-1:0] prdata,
    input logic               pready
);

    // stalled result stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // input side only blocks while an output item is stalled
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("input blocked without output stall");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == STAT_OK || m_tuser == STAT_SAT || m_tuser == STAT_ZERO))
        else $error("bad status code");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == STAT_ZERO |-> m_tdata == '0)
        else $error("zero-length item with non-zero coordinates");

endmodule

bind polar_stereographic_projection_top psp_checker u_psp_checker (.*);
